FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the run-length decoder.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is low.
`define ORDL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ORDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ORDL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ORDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/ordl_pkg.sv
// Types and fixed constants of the run-length decoder.
// Depends on nothing; used by the cell walker, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ordl_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 6;
    localparam int ADDR_W = 11;
    localparam int CODE_W = 9;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 9;
    localparam int RUN_W  = 6;

    localparam logic [BYTE_W-1:0] BYTE_ESCAPE = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_BANK   = 8'hff;
    localparam logic [CNT_W-1:0]  COUNT_SAT   = 9'h1ff;
    localparam int                CTRL_BANK_BIT  = 6;
    localparam int                CTRL_BLINK_BIT = 7;

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_CTRL,
        PH_RUNCH,
        PH_BANKCH
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic              start_req;
        logic [BYTE_W-1:0] data_byte;
        logic [ROW_W-1:0]  start_row;
        logic [COL_W-1:0]  start_col;
        logic [ROW_W-1:0]  grid_rows;
        logic [COL_W-1:0]  grid_cols;
        logic [ROW_W-1:0]  wrap_rows;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] cell_address;
        logic [CODE_W-1:0] char_code;
        logic              blink_on;
        logic              frame_complete;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic             load;
        logic             advance;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] cols;
        logic [ROW_W-1:0] wrap;
    } t_walk_ctl;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              in_store;
        logic              frame;
    } t_walk_stat;

endpackage

`default_nettype wire

FILE: rtl/core/ordl_stream_if.sv
// Valid/ready stream channel carrying one payload struct per request.
// Depends on nothing; the payload type comes from ordl_pkg at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface ordl_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ordl_cell_walker.sv
// Cursor unit: holds the row/column position, forms the cell address and
// steps the cursor with column and row wrap. Depends on ordl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ordl_cell_walker #(
    parameter int LINE_STRIDE = 64,
    parameter int MAX_ROWS    = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ordl_pkg::t_walk_ctl    i_ctl,
    output ordl_pkg::t_walk_stat   o_stat
);
    import ordl_pkg::*;

    localparam int FULL_W = ADDR_W + 1;
    localparam logic [FULL_W-1:0] STORE_END = FULL_W'(MAX_ROWS * LINE_STRIDE);

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [COL_W-1:0]  r_cols;
    logic [ROW_W-1:0]  r_wrap;
    logic [FULL_W-1:0] w_addr;
    logic              w_frame;

    always_comb begin
        w_addr = FULL_W'(r_row) * FULL_W'(LINE_STRIDE) + FULL_W'(r_col);
    end

    // Step the column; wrap into the next row, and the row at the wrap count.
    always_comb begin
        n_col   = r_col + 1'b1;
        n_row   = r_row;
        w_frame = 1'b0;
        if (n_col == r_cols) begin
            n_col = '0;
            n_row = r_row + 1'b1;
            if (n_row == r_wrap) begin
                n_row   = '0;
                w_frame = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_cols <= '0;
            r_wrap <= '0;
        end else if (i_ctl.load) begin
            r_row  <= i_ctl.row;
            r_col  <= i_ctl.col;
            r_cols <= i_ctl.cols;
            r_wrap <= i_ctl.wrap;
        end else if (i_ctl.advance) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_stat.addr     = w_addr[ADDR_W-1:0];
    assign o_stat.in_store = (w_addr < STORE_END);
    assign o_stat.frame    = w_frame;

endmodule

`default_nettype wire

FILE: rtl/core/osd_run_length_decoder.sv
// Run-length decoder for screen character streams: top level with the token
// parser, write sequencer and output register. Depends on ordl_pkg,
// ordl_stream_if, ordl_cell_walker and assert_macros.svh.
//
// A start request opens a message at the given row and column and latches the
// column count and wrap row count; a start outside the grid leaves the message
// closed. Data requests are parsed one byte at a time: byte 0 escapes into a
// control byte (run count in bits 5..0, zero closes the message, bits 6 and 7
// toggle bank and blink), byte 255 toggles the bank from the next character,
// and any other byte is one literal character. Each character write gives a
// cell address, a 9-bit code with the bank in bit 8, the blink flag and a
// frame flag when the row wraps at the wrap count; last marks the final write
// of the request. Writes at or beyond MAX_ROWS * LINE_STRIDE are dropped but
// still move the cursor. After BYTE_LIMIT bytes no new token starts.
// Sequence: a request that writes a run of cells is accepted, then each cell is
// stepped through the single shared cursor unit (ordl_cell_walker), then the
// held write is flushed with its last flag. The input is not ready while a run
// is in progress, and a stalled output holds the sequencer once the one-write
// hold slot is full.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module osd_run_length_decoder #(
    parameter int LINE_STRIDE = 64,
    parameter int MAX_ROWS    = 32,
    parameter int BYTE_LIMIT  = 395
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ordl_stream_if.sink    i_in,
    ordl_stream_if.source  o_out
);
    import ordl_pkg::*;

    // Sequencer state.
    t_state r_state, n_state;

    // Token parser state.
    t_phase            r_phase, n_phase;
    logic              r_active, n_active;
    logic              r_bank, n_bank;
    logic              r_blink, n_blink;
    logic [RUN_W-1:0]  r_pending, n_pending;
    logic [CNT_W-1:0]  r_bytes, n_bytes;

    // Run in progress.
    logic [RUN_W-1:0]  r_left;
    logic [BYTE_W-1:0] r_char;

    // One write held back until the next one shows whether it is the last.
    logic              r_hold_valid;
    t_out_item         r_hold;
    logic              r_out_valid;
    t_out_item         r_out;

    t_in_item          w_in;
    logic              w_accept;
    logic              w_launch;
    logic [RUN_W-1:0]  w_count;
    logic              w_out_free;
    logic              w_emit;
    logic              w_step_go;
    logic              w_push;
    logic              w_push_last;
    t_out_item         w_new;
    t_out_item         w_out_next;
    t_walk_ctl         w_walk_ctl;
    t_walk_stat        w_walk_stat;

    assign w_in       = i_in.payload;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Token decode of one accepted start or data request.
    always_comb begin
        n_phase   = r_phase;
        n_active  = r_active;
        n_bank    = r_bank;
        n_blink   = r_blink;
        n_pending = r_pending;
        n_bytes   = r_bytes;
        w_launch  = 1'b0;
        w_count   = RUN_W'(1);
        if (w_in.start_req) begin
            n_phase   = PH_PLAIN;
            n_bank    = 1'b0;
            n_blink   = 1'b0;
            n_pending = '0;
            n_bytes   = '0;
            n_active  = (w_in.start_row < w_in.grid_rows) &&
                        (w_in.start_col < w_in.grid_cols);
        end else if (r_active) begin
            if (r_phase == PH_PLAIN && r_bytes >= CNT_W'(BYTE_LIMIT)) begin
                // Limit reached between tokens: close and drop the byte.
                n_active = 1'b0;
            end else begin
                if (r_bytes != COUNT_SAT) begin
                    n_bytes = r_bytes + 1'b1;
                end
                unique case (r_phase)
                    PH_PLAIN: begin
                        if (w_in.data_byte == BYTE_ESCAPE) begin
                            n_phase = PH_CTRL;
                        end else if (w_in.data_byte == BYTE_BANK) begin
                            n_bank  = !r_bank;
                            n_phase = PH_BANKCH;
                        end else begin
                            w_launch = 1'b1;
                        end
                    end
                    PH_CTRL: begin
                        n_pending = w_in.data_byte[RUN_W-1:0];
                        if (w_in.data_byte[RUN_W-1:0] == '0) begin
                            n_active = 1'b0;
                            n_phase  = PH_PLAIN;
                        end else begin
                            n_bank  = r_bank ^ w_in.data_byte[CTRL_BANK_BIT];
                            n_blink = r_blink ^ w_in.data_byte[CTRL_BLINK_BIT];
                            n_phase = PH_RUNCH;
                        end
                    end
                    PH_RUNCH: begin
                        n_phase  = PH_PLAIN;
                        w_launch = 1'b1;
                        w_count  = r_pending;
                    end
                    PH_BANKCH: begin
                        n_phase  = PH_PLAIN;
                        w_launch = 1'b1;
                    end
                endcase
            end
        end
    end

    // Next state of the write sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_launch) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_step_go && r_left == RUN_W'(1)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_hold_valid || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: cursor control, hold and push decisions.
    always_comb begin
        w_new.cell_address   = w_walk_stat.addr;
        w_new.char_code      = {r_bank, r_char};
        w_new.blink_on       = r_blink;
        w_new.frame_complete = w_walk_stat.frame;
        w_new.last           = 1'b0;
        w_emit               = w_walk_stat.in_store;
        w_step_go            = 1'b0;
        w_push               = 1'b0;
        w_push_last          = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_RUN: begin
                // Stall only when a new write must displace a held one.
                w_step_go = !(w_emit && r_hold_valid && !w_out_free);
                w_push    = w_step_go && w_emit && r_hold_valid;
            end
            ST_FLUSH: begin
                w_push      = r_hold_valid && w_out_free;
                w_push_last = 1'b1;
            end
            default: begin
            end
        endcase
        w_out_next         = r_hold;
        w_out_next.last    = w_push_last;
        w_walk_ctl.load    = w_accept && w_in.start_req;
        w_walk_ctl.advance = w_step_go;
        w_walk_ctl.row     = w_in.start_row;
        w_walk_ctl.col     = w_in.start_col;
        w_walk_ctl.cols    = w_in.grid_cols;
        w_walk_ctl.wrap    = w_in.wrap_rows;
    end

    ordl_cell_walker #(
        .LINE_STRIDE (LINE_STRIDE),
        .MAX_ROWS    (MAX_ROWS)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_walk_ctl),
        .o_stat  (w_walk_stat)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_PLAIN;
            r_active     <= 1'b0;
            r_bank       <= 1'b0;
            r_blink      <= 1'b0;
            r_pending    <= '0;
            r_bytes      <= '0;
            r_left       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_phase   <= n_phase;
                r_active  <= n_active;
                r_bank    <= n_bank;
                r_blink   <= n_blink;
                r_pending <= n_pending;
                r_bytes   <= n_bytes;
            end
            if (w_accept && w_launch) begin
                r_left <= w_count;
            end else if (w_step_go) begin
                r_left <= r_left - 1'b1;
            end
            if (w_step_go && w_emit) begin
                r_hold_valid <= 1'b1;
            end else if (w_push) begin
                r_hold_valid <= 1'b0;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_launch) begin
            r_char <= w_in.data_byte;
        end
        if (w_step_go && w_emit) begin
            r_hold <= w_new;
        end
        if (w_push) begin
            r_out <= w_out_next;
        end
    end

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Accepting a request means no write is still held back.
    `ORDL_ASSERT_IMPL(a_idle_hold_empty, i_clk, i_rst_n, i_in.ready, !r_hold_valid, "write held while ready")
    // A run in progress always has cells left to write.
    `ORDL_ASSERT_IMPL(a_run_left, i_clk, i_rst_n, r_state == ST_RUN, r_left != '0, "run with zero count")
    // The final cell of a run hands over to the flush step.
    `ORDL_ASSERT_NEXT(a_run_to_flush, i_clk, i_rst_n, (r_state == ST_RUN) && w_step_go && (r_left == RUN_W'(1)), r_state == ST_FLUSH, "run end missed flush")

endmodule

`default_nettype wire

FILE: tb/tb_osd_run_length_decoder.sv
// Self-checking testbench for osd_run_length_decoder: directed table, then random messages.
// Depends on ordl_pkg and ordl_stream_if. Every cell write is checked against a predictor
// that runs inside this module.
`timescale 1ns / 1ps

module tb_osd_run_length_decoder;

    import ordl_pkg::*;

    localparam int LINE_STRIDE  = 64;
    localparam int MAX_ROWS     = 32;
    localparam int BYTE_LIMIT   = 395;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    // Leave room at the end for a run of 63 cells to pass through the block.
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 500;
    // Assume the worst slow case: about a thousand requests of 63 cell writes each, every
    // write held by the longest sink stall. Then take that several times.
    localparam int CYCLE_LIMIT  = 10000000;

    // Ways the sink stalls. Each one holds for a random stretch of cycles.
    typedef enum int {
        SINK_OPEN,      // always ready
        SINK_COIN,      // ready on a coin toss
        SINK_COMB,      // ready except when the span count is a multiple of four
        SINK_CHOKE      // one ready cycle, then a long stall
    } t_sink_mode;

    // One row of the directed table. When typed is set, the row gives the expected write
    // itself: one write if one_write is set, otherwise none.
    typedef struct packed {
        t_in_item  rq;
        logic      typed;
        logic      one_write;
        t_out_item w;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ordl_stream_if #(.t_payload(t_in_item))  byte_if ();
    ordl_stream_if #(.t_payload(t_out_item)) cell_if ();

    osd_run_length_decoder #(
        .LINE_STRIDE (LINE_STRIDE),
        .MAX_ROWS    (MAX_ROWS),
        .BYTE_LIMIT  (BYTE_LIMIT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (cell_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decoder predictor. Its state matches the block's state after reset.
    // ------------------------------------------------------------------
    logic             in_message  = 1'b0;
    t_phase           parse_phase = PH_PLAIN;
    logic             hi_bank     = 1'b0;
    logic             blinking    = 1'b0;
    logic [RUN_W-1:0] run_count   = '0;
    logic [ROW_W-1:0] row_ptr     = '0;
    logic [COL_W-1:0] col_ptr     = '0;
    logic [ROW_W-1:0] rows_lim    = '0;
    logic [COL_W-1:0] cols_lim    = '0;
    logic [ROW_W-1:0] wrap_lim    = '0;
    logic [CNT_W-1:0] bytes_taken = '0;

    // Cell writes still to come from the block, oldest first.
    t_out_item cell_writes_due [$];

    // Directed table, walked in order.
    t_stim_row directed_steps [$];

    int errors      = 0;
    int cycle_count = 0;
    int burst_left  = 0;

    // Append one write to the tail of the expected writes.
    function automatic void expect_write(input t_out_item w);
        cell_writes_due.insert(cell_writes_due.size(), w);
    endfunction

    // Write one character count times at the cursor and move the cursor after each write.
    // Writes past the end of the store still move the cursor, but give no result. The last
    // result of the request is held back until the end so that it can carry the last flag.
    function automatic void write_cells(input logic [BYTE_W-1:0] ch,
                                        input logic [RUN_W-1:0] count);
        t_out_item held;
        bit        have_held;
        int        addr;
        logic      frame;
        have_held = 1'b0;
        held      = '0;
        for (int i = 0; i < count; i++) begin
            addr  = int'(row_ptr) * LINE_STRIDE + int'(col_ptr);
            frame = 1'b0;
            col_ptr = col_ptr + 1'b1;
            if (col_ptr == cols_lim) begin
                col_ptr = '0;
                row_ptr = row_ptr + 1'b1;
                // The row counter is five bits wide. With a wrap count of zero, the frame
                // flag therefore rises only when the row passes 31.
                if (row_ptr == wrap_lim) begin
                    row_ptr = '0;
                    frame   = 1'b1;
                end
            end
            if (addr < MAX_ROWS * LINE_STRIDE) begin
                if (have_held)
                    expect_write(held);
                held.cell_address   = addr[ADDR_W-1:0];
                held.char_code      = {hi_bank, ch};
                held.blink_on       = blinking;
                held.frame_complete = frame;
                held.last           = 1'b0;
                have_held           = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            expect_write(held);
        end
    endfunction

    // Advance the token parser by one accepted request and queue the writes it causes.
    function automatic void decode_request(input t_in_item rq);
        if (rq.start_req) begin
            rows_lim    = rq.grid_rows;
            cols_lim    = rq.grid_cols;
            wrap_lim    = rq.wrap_rows;
            parse_phase = PH_PLAIN;
            hi_bank     = 1'b0;
            blinking    = 1'b0;
            run_count   = '0;
            bytes_taken = '0;
            row_ptr     = rq.start_row;
            col_ptr     = rq.start_col;
            in_message  = (rq.start_row < rq.grid_rows) && (rq.start_col < rq.grid_cols);
            return;
        end
        if (!in_message)
            return;
        // Past the byte limit, close the message before a new token starts. A token that
        // has already started still runs to its end.
        if (parse_phase == PH_PLAIN && bytes_taken >= BYTE_LIMIT) begin
            in_message = 1'b0;
            return;
        end
        if (bytes_taken != COUNT_SAT)
            bytes_taken = bytes_taken + 1'b1;
        case (parse_phase)
            PH_PLAIN: begin
                if (rq.data_byte == BYTE_ESCAPE) begin
                    parse_phase = PH_CTRL;
                end else if (rq.data_byte == BYTE_BANK) begin
                    hi_bank     = ~hi_bank;
                    parse_phase = PH_BANKCH;
                end else begin
                    write_cells(rq.data_byte, RUN_W'(1));
                end
            end
            PH_CTRL: begin
                run_count = rq.data_byte[RUN_W-1:0];
                if (run_count == 0) begin
                    in_message  = 1'b0;
                    parse_phase = PH_PLAIN;
                end else begin
                    if (rq.data_byte[CTRL_BANK_BIT])
                        hi_bank = ~hi_bank;
                    if (rq.data_byte[CTRL_BLINK_BIT])
                        blinking = ~blinking;
                    parse_phase = PH_RUNCH;
                end
            end
            PH_RUNCH: begin
                parse_phase = PH_PLAIN;
                write_cells(rq.data_byte, run_count);
            end
            default: begin
                parse_phase = PH_PLAIN;
                write_cells(rq.data_byte, RUN_W'(1));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request builders. Fields that the block ignores get random values.
    // ------------------------------------------------------------------
    function automatic t_in_item data_req(input logic [BYTE_W-1:0] b);
        t_in_item    rq;
        logic [63:0] noise;
        noise        = {$urandom, $urandom};
        rq           = noise[$bits(t_in_item)-1:0];
        rq.start_req = 1'b0;
        rq.data_byte = b;
        return rq;
    endfunction

    function automatic t_in_item start_req(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                           input logic [ROW_W-1:0] rows,
                                           input logic [COL_W-1:0] cols,
                                           input logic [ROW_W-1:0] wrap);
        t_in_item rq;
        rq.start_req = 1'b1;
        rq.data_byte = BYTE_W'($urandom);
        rq.start_row = r;
        rq.start_col = c;
        rq.grid_rows = rows;
        rq.grid_cols = cols;
        rq.wrap_rows = wrap;
        return rq;
    endfunction

    // Build a single write as it is read off the stream: blink off, last set.
    function automatic t_out_item one_cell(input logic [ADDR_W-1:0] addr,
                                           input logic [CODE_W-1:0] code, input logic frame);
        t_out_item w;
        w.cell_address   = addr;
        w.char_code      = code;
        w.blink_on       = 1'b0;
        w.frame_complete = frame;
        w.last           = 1'b1;
        return w;
    endfunction

    // Append one row to the directed table.
    function automatic void add_step(input t_in_item rq, input bit typed,
                                     input bit one_write, input t_out_item w);
        t_stim_row s;
        s.rq        = rq;
        s.typed     = typed;
        s.one_write = one_write;
        s.w         = w;
        directed_steps.insert(directed_steps.size(), s);
    endfunction

    // ------------------------------------------------------------------
    // Source side: send in bursts of random length with random gaps between them.
    // ------------------------------------------------------------------
    task automatic pace();
        int gap;
        if (burst_left != 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(10, 60);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drive one request at the falling edge and keep valid high until a rising edge
    // samples ready. Predict at acceptance. On a typed row, replace the predicted writes
    // with the writes given in the table.
    task automatic send_request(input t_in_item rq, input bit typed, input bit one_write,
                                input t_out_item w);
        int mark;
        byte_if.valid   <= 1'b1;
        byte_if.payload <= rq;
        forever begin
            @(posedge i_clk);
            if (byte_if.ready)
                break;
        end
        mark = cell_writes_due.size();
        decode_request(rq);
        if (typed) begin
            while (cell_writes_due.size() > mark)
                cell_writes_due.delete(cell_writes_due.size() - 1);
            if (one_write)
                expect_write(w);
        end
        @(negedge i_clk);
        pace();
    endtask

    task automatic send_data(input logic [BYTE_W-1:0] b);
        send_request(data_req(b), 1'b0, 1'b0, '0);
    endtask

    // Stop sending until every expected write has been taken.
    task automatic hold_until_drained();
        byte_if.valid <= 1'b0;
        @(negedge i_clk);
        while (cell_writes_due.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sink side: change ready at the falling edge. Pick a new stall mode at random
    // after each stretch of cycles.
    // ------------------------------------------------------------------
    initial begin : cell_sink
        t_sink_mode mode;
        int         span;
        int         hold;
        cell_if.ready = 1'b0;
        mode = SINK_OPEN;
        span = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                mode = t_sink_mode'($urandom_range(0, 3));
                span = $urandom_range(40, 250);
            end
            span--;
            case (mode)
                SINK_OPEN: cell_if.ready <= 1'b1;
                SINK_COIN: cell_if.ready <= 1'($urandom_range(0, 1));
                SINK_COMB: cell_if.ready <= (span % 4 != 0);
                default: begin
                    if (hold != 0) begin
                        hold--;
                        cell_if.ready <= 1'b0;
                    end else begin
                        hold = $urandom_range(4, 20);
                        cell_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output check: compare each accepted write, field by field, with the oldest expected one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : cell_check
        t_out_item want;
        if (i_rst_n && cell_if.valid && cell_if.ready) begin
            if (cell_writes_due.size() == 0) begin
                $error("unexpected cell write: address %0d code %0h",
                       cell_if.payload.cell_address, cell_if.payload.char_code);
                errors++;
            end else begin
                want = cell_writes_due.pop_front();
                if (cell_if.payload.cell_address !== want.cell_address) begin
                    $error("cell_address: expected %0d, got %0d",
                           want.cell_address, cell_if.payload.cell_address);
                    errors++;
                end
                if (cell_if.payload.char_code !== want.char_code) begin
                    $error("char_code: expected %0h, got %0h",
                           want.char_code, cell_if.payload.char_code);
                    errors++;
                end
                if (cell_if.payload.blink_on !== want.blink_on) begin
                    $error("blink_on: expected %0b, got %0b",
                           want.blink_on, cell_if.payload.blink_on);
                    errors++;
                end
                if (cell_if.payload.frame_complete !== want.frame_complete) begin
                    $error("frame_complete: expected %0b, got %0b",
                           want.frame_complete, cell_if.payload.frame_complete);
                    errors++;
                end
                if (cell_if.payload.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, cell_if.payload.last);
                    errors++;
                end
            end
        end
    end

    // Stop a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_in_item         srq;
        logic [BYTE_W-1:0] ctrl;
        int               g_rows;
        int               g_cols;
        int               items_done;
        int               msg_len;
        int               sent;
        int               k;
        bit               ended;
        bit               opened;
        bit               long_msg;
        bit               long_done;

        byte_if.valid   = 1'b0;
        byte_if.payload = '0;
        i_rst_n         = 1'b0;

        // Directed table. Rows with a typed write or none can be read off at a glance.
        // The runs are left to the predictor.
        // Drop data while no message is open.
        add_step(data_req(8'h41), 1, 0, '0);
        // Keep the message closed for a start outside the grid, by row and then by column.
        add_step(start_req(5, 0, 5, 10, 5), 1, 0, '0);
        add_step(data_req(8'h41), 1, 0, '0);
        add_step(start_req(0, 40, 4, 40, 4), 1, 0, '0);
        // Open the widest grid at the origin.
        add_step(start_req(0, 0, 31, 63, 31), 1, 0, '0);
        add_step(data_req(8'h01), 1, 1, one_cell(0, 9'h001, 0));
        add_step(data_req(8'hfe), 1, 1, one_cell(1, 9'h0fe, 0));
        // Bank escape: the high bank stays selected, even for a character of zero.
        add_step(data_req(BYTE_BANK), 1, 0, '0);
        add_step(data_req(8'h00), 1, 1, one_cell(2, 9'h100, 0));
        add_step(data_req(8'h80), 1, 1, one_cell(3, 9'h180, 0));
        // Run of three that toggles bank and blink.
        add_step(data_req(BYTE_ESCAPE), 1, 0, '0);
        add_step(data_req(8'hc3), 1, 0, '0);
        add_step(data_req(8'hff), 0, 0, '0);
        // Longest run, which wraps the column into the next row.
        add_step(data_req(BYTE_ESCAPE), 1, 0, '0);
        add_step(data_req(8'h3f), 1, 0, '0);
        add_step(data_req(8'h55), 0, 0, '0);
        // A zero count closes the message, whatever the top bits hold.
        add_step(data_req(BYTE_ESCAPE), 1, 0, '0);
        add_step(data_req(8'hc0), 1, 0, '0);
        add_step(data_req(8'h41), 1, 0, '0);
        // Tiny grid: the first write wraps the row at the wrap count and completes a frame.
        add_step(start_req(1, 2, 2, 3, 2), 1, 0, '0);
        add_step(data_req(8'h7f), 1, 1, one_cell(66, 9'h07f, 1));
        // A new start replaces the open message. Start at the far corner with a wrap count of zero.
        add_step(start_req(30, 62, 31, 63, 0), 1, 0, '0);
        add_step(data_req(BYTE_ESCAPE), 1, 0, '0);
        add_step(data_req(8'h42), 1, 0, '0);
        add_step(data_req(8'h20), 0, 0, '0);

        // Hold reset, then release it at a falling edge.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_steps[i])
            send_request(directed_steps[i].rq, directed_steps[i].typed,
                         directed_steps[i].one_write, directed_steps[i].w);

        // Let the block drain completely once before the random part.
        hold_until_drained();

        // Random messages. Most are well formed with random content. The rest break off
        // in the middle of a token, start outside the grid, or are followed by stray bytes.
        // At least one message is sent past the byte limit.
        items_done = 0;
        long_done  = 1'b0;
        while (items_done < RANDOM_ITEMS) begin
            long_msg = (!long_done && items_done >= RANDOM_ITEMS / 2) ||
                       ($urandom_range(0, 39) == 0);
            if (long_msg)
                long_done = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                srq = start_req(ROW_W'($urandom), COL_W'($urandom), ROW_W'($urandom),
                                COL_W'($urandom), ROW_W'($urandom));
            end else begin
                g_rows = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 4) : $urandom_range(1, 31);
                g_cols = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 63);
                srq = start_req(ROW_W'($urandom_range(0, g_rows - 1)),
                                COL_W'($urandom_range(0, g_cols - 1)),
                                ROW_W'(g_rows), COL_W'(g_cols),
                                ROW_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                                   : $urandom_range(1, g_rows)));
            end
            opened = (srq.start_row < srq.grid_rows) && (srq.start_col < srq.grid_cols);
            send_request(srq, 1'b0, 1'b0, '0);

            msg_len = long_msg ? $urandom_range(BYTE_LIMIT, BYTE_LIMIT + 30)
                               : $urandom_range(1, 40);
            sent  = 0;
            ended = 1'b0;
            while (sent < msg_len && !ended) begin
                // Do not let a long message close early.
                k = long_msg ? $urandom_range(0, 89) : $urandom_range(0, 99);
                if (k < 45) begin
                    send_data(BYTE_W'($urandom_range(1, 254)));
                    sent += 1;
                end else if (k < 60) begin
                    send_data(BYTE_BANK);
                    send_data(BYTE_W'($urandom_range(0, 255)));
                    sent += 2;
                end else if (k < 90) begin
                    ctrl[RUN_W-1:0] = RUN_W'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                                                         : $urandom_range(1, 63));
                    ctrl[CTRL_BANK_BIT]  = 1'($urandom_range(0, 1));
                    ctrl[CTRL_BLINK_BIT] = 1'($urandom_range(0, 1));
                    send_data(BYTE_ESCAPE);
                    send_data(ctrl);
                    send_data(BYTE_W'($urandom_range(0, 255)));
                    sent += 3;
                end else if (k < 95) begin
                    // Close the message with a zero count.
                    ctrl                 = '0;
                    ctrl[CTRL_BANK_BIT]  = 1'($urandom_range(0, 1));
                    ctrl[CTRL_BLINK_BIT] = 1'($urandom_range(0, 1));
                    send_data(BYTE_ESCAPE);
                    send_data(ctrl);
                    sent += 2;
                    ended = 1'b1;
                end else begin
                    // Break off in the middle of a token. The next start cuts it short.
                    send_data(($urandom_range(0, 1) != 0) ? BYTE_ESCAPE : BYTE_BANK);
                    sent += 1;
                    ended = 1'b1;
                end
            end
            items_done += opened ? sent + 1 : 1;

            // Send stray bytes after the message. They may fall on a closed message.
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) send_data(BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0)
                hold_until_drained();
        end

        // Let the last writes through, then watch a while longer for writes that nobody asked for.
        byte_if.valid <= 1'b0;
        while (cell_writes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (cell_writes_due.size() != 0)
            errors++;

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
